[hw/rtl/mts_pkg.sv]
// Shared types, codes and default sizes for the multithread issue scheduler.
package mts_pkg;

   localparam int MAX_THREADS_DEF   = 8;
   localparam int PC_WIDTH_DEF      = 16;
   localparam int LATENCY_WIDTH_DEF = 8;
   localparam int COUNT_WIDTH_DEF   = 32;

   localparam int KIND_WIDTH     = 2;
   localparam int PENALTY_WIDTH  = 8;
   localparam int TCOUNT_WIDTH   = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_INDEX_LSB  = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PLAIN,
      KIND_LOAD,
      KIND_STORE,
      KIND_HALT
   } kind_type;

   typedef enum logic [1:0] {
      ACT_DONE,
      ACT_IDLE,
      ACT_PENALTY,
      ACT_ISSUE
   } act_type;

   typedef enum logic [2:0] {
      REG_FINE_MODE,
      REG_LOAD_LATENCY,
      REG_STORE_LATENCY,
      REG_SWITCH_PENALTY,
      REG_THREAD_COUNT
   } reg_index_type;

   typedef struct packed {
      act_type act;
      logic    new_switch;
      logic    all_halted;
   } plan_type;

endpackage

[hw/rtl/mts_pick.sv]
// Thread selection: round-robin search for the next ready thread and the cycle plan.
module mts_pick #(
   parameter int MAX_THREADS = mts_pkg::MAX_THREADS_DEF
) (
   input  logic [MAX_THREADS-1:0]               ready,
   input  logic [MAX_THREADS-1:0]               halted,
   input  logic [$clog2(MAX_THREADS)-1:0]       cur,
   input  logic [mts_pkg::TCOUNT_WIDTH-1:0]     thread_count,
   input  logic                                 fine_mode,
   input  logic                                 penalty_busy,
   input  logic                                 penalty_armed,
   output mts_pkg::plan_type                    plan,
   output logic [$clog2(MAX_THREADS)-1:0]       thr,
   output logic [$clog2(MAX_THREADS+1)-1:0]     use_count
);
   import mts_pkg::*;

   localparam int TW = $clog2(MAX_THREADS);
   localparam int NW = $clog2(MAX_THREADS + 1);
   localparam int RW = 2 * TW + 1;

   logic [RW-1:0]          rem_w;
   logic [RW-1:0]          sub_w;
   logic [TW-1:0]          base;
   logic [MAX_THREADS-1:0] in_use;
   logic [MAX_THREADS-1:0] ready_use;
   logic [MAX_THREADS-1:0] ready_hi;
   logic                   found_hi;
   logic                   found_any;
   logic [TW-1:0]          thr_hi;
   logic [TW-1:0]          thr_any;

   always_comb begin
      if (thread_count == '0) begin
         use_count = NW'(1);
      end else if (int'(thread_count) > MAX_THREADS) begin
         use_count = NW'(MAX_THREADS);
      end else begin
         use_count = NW'(thread_count);
      end
   end

   // The current thread can lie beyond a reduced thread count, so reduce it
   // by restoring remainder steps, one per index bit.
   always_comb begin
      rem_w = RW'(cur);
      sub_w = '0;
      for (int s = TW - 1; s >= 0; s--) begin
         sub_w = RW'(use_count) << s;
         if (rem_w >= sub_w) begin
            rem_w = rem_w - sub_w;
         end
      end
      base = rem_w[TW-1:0];
   end

   always_comb begin
      for (int i = 0; i < MAX_THREADS; i++) begin
         in_use[i]    = i < int'(use_count);
         ready_use[i] = ready[i] && in_use[i];
         ready_hi[i]  = ready_use[i] && (i >= int'(base));
      end
   end

   always_comb begin
      found_hi  = 1'b0;
      found_any = 1'b0;
      thr_hi    = '0;
      thr_any   = '0;
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
         if (ready_hi[i]) begin
            found_hi = 1'b1;
            thr_hi   = TW'(i);
         end
         if (ready_use[i]) begin
            found_any = 1'b1;
            thr_any   = TW'(i);
         end
      end
   end

   always_comb begin
      plan.all_halted = &(halted | ~in_use);
      plan.new_switch = 1'b0;
      plan.act        = ACT_IDLE;
      thr             = '0;
      if (plan.all_halted) begin
         plan.act = ACT_DONE;
      end else if (penalty_busy) begin
         plan.act = ACT_PENALTY;
         thr      = base;
      end else if (found_any) begin
         thr = found_hi ? thr_hi : thr_any;
         if (!fine_mode && (thr != base) && penalty_armed) begin
            plan.act        = ACT_PENALTY;
            plan.new_switch = 1'b1;
         end else begin
            plan.act = ACT_ISSUE;
         end
      end
   end

endmodule

[hw/rtl/multithread_issue_scheduler.sv]
// Top level of the multithread issue scheduler: thread state, counters, CSRs and result register.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_instr_kind
//   rsp_      out        rsp_valid/rsp_stall  issue, next-issue, halt and count fields
//   csr_      in/out     APB psel/penable     registers at byte address 4*i
//
// Each transfer on req_ is one scheduler cycle; a new one is taken
// every clock while the result register is empty or is being drained in that clock.
// The thread pick is one round-robin priority search over the thread ready vector.
// Reset clears all thread state, counters, configuration registers and the result valid flag; thread_count resets to 8.
// While rsp_stall holds a result, req_stall is raised and the state does not move.
module multithread_issue_scheduler #(
   parameter int MAX_THREADS   = mts_pkg::MAX_THREADS_DEF,
   parameter int PC_WIDTH      = mts_pkg::PC_WIDTH_DEF,
   parameter int LATENCY_WIDTH = mts_pkg::LATENCY_WIDTH_DEF,
   parameter int COUNT_WIDTH   = mts_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mts_pkg::KIND_WIDTH-1:0]      req_instr_kind,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_issued,
   output logic [$clog2(MAX_THREADS)-1:0]      rsp_issue_thread,
   output logic [PC_WIDTH-1:0]                 rsp_issue_pc,
   output logic                                rsp_penalty_cycle,
   output logic                                rsp_next_issues,
   output logic [$clog2(MAX_THREADS)-1:0]      rsp_coming_thread,
   output logic [PC_WIDTH-1:0]                 rsp_next_pc,
   output logic                                rsp_all_halted,
   output logic [COUNT_WIDTH-1:0]              rsp_cycle_total,
   output logic [COUNT_WIDTH-1:0]              rsp_instr_total,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mts_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mts_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mts_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import mts_pkg::*;

   localparam int TW = $clog2(MAX_THREADS);
   localparam int NW = $clog2(MAX_THREADS + 1);
   localparam int WW = LATENCY_WIDTH + 1;

   // Configuration registers.
   logic                      fine_mode_ff;
   logic [LATENCY_WIDTH-1:0]  load_latency_ff;
   logic [LATENCY_WIDTH-1:0]  store_latency_ff;
   logic [PENALTY_WIDTH-1:0]  switch_penalty_ff;
   logic [TCOUNT_WIDTH-1:0]   thread_count_ff;
   logic                      csr_write;
   reg_index_type             csr_index;

   // Thread and scheduler state.
   logic [WW-1:0]             wait_ff [MAX_THREADS];
   logic [WW-1:0]             wait_in [MAX_THREADS];
   logic [PC_WIDTH-1:0]       pc_ff   [MAX_THREADS];
   logic [PC_WIDTH-1:0]       pc_in   [MAX_THREADS];
   logic [MAX_THREADS-1:0]    halted_ff;
   logic [MAX_THREADS-1:0]    halted_in;
   logic [TW-1:0]             current_ff;
   logic [TW-1:0]             current_in;
   logic [PENALTY_WIDTH-1:0]  penalty_left_ff;
   logic [PENALTY_WIDTH-1:0]  penalty_left_in;
   logic [COUNT_WIDTH-1:0]    cycle_ff;
   logic [COUNT_WIDTH-1:0]    cycle_in;
   logic [COUNT_WIDTH-1:0]    instr_ff;
   logic [COUNT_WIDTH-1:0]    instr_in;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      issued_ff;
   logic                      issued_in;
   logic [TW-1:0]             issue_thread_ff;
   logic [TW-1:0]             issue_thread_in;
   logic [PC_WIDTH-1:0]       issue_pc_ff;
   logic [PC_WIDTH-1:0]       issue_pc_in;
   logic                      penalty_cycle_ff;
   logic                      penalty_cycle_in;

   logic [MAX_THREADS-1:0]    ready;
   plan_type                  plan;
   logic [TW-1:0]             pick_thr;
   logic [NW-1:0]             use_count;
   logic [NW-1:0]             thr_plus_one;
   logic                      accept;
   kind_type                  kind;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_mode_ff      <= 1'b0;
         load_latency_ff   <= '0;
         store_latency_ff  <= '0;
         switch_penalty_ff <= '0;
         thread_count_ff   <= TCOUNT_WIDTH'(MAX_THREADS_DEF);
      end else if (csr_write) begin
         case (csr_index)
            REG_FINE_MODE:      fine_mode_ff      <= csr_pwdata[0];
            REG_LOAD_LATENCY:   load_latency_ff   <= csr_pwdata[LATENCY_WIDTH-1:0];
            REG_STORE_LATENCY:  store_latency_ff  <= csr_pwdata[LATENCY_WIDTH-1:0];
            REG_SWITCH_PENALTY: switch_penalty_ff <= csr_pwdata[PENALTY_WIDTH-1:0];
            REG_THREAD_COUNT:   thread_count_ff   <= csr_pwdata[TCOUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_FINE_MODE:      csr_prdata = CSR_DATA_WIDTH'(fine_mode_ff);
         REG_LOAD_LATENCY:   csr_prdata = CSR_DATA_WIDTH'(load_latency_ff);
         REG_STORE_LATENCY:  csr_prdata = CSR_DATA_WIDTH'(store_latency_ff);
         REG_SWITCH_PENALTY: csr_prdata = CSR_DATA_WIDTH'(switch_penalty_ff);
         REG_THREAD_COUNT:   csr_prdata = CSR_DATA_WIDTH'(thread_count_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < MAX_THREADS; i++) begin
         ready[i] = (wait_ff[i] == '0) && !halted_ff[i];
      end
   end

   mts_pick #(
      .MAX_THREADS (MAX_THREADS)
   ) u_pick (
      .ready         (ready),
      .halted        (halted_ff),
      .cur           (current_ff),
      .thread_count  (thread_count_ff),
      .fine_mode     (fine_mode_ff),
      .penalty_busy  (penalty_left_ff != '0),
      .penalty_armed (switch_penalty_ff != '0),
      .plan          (plan),
      .thr           (pick_thr),
      .use_count     (use_count)
   );

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign kind         = kind_type'(req_instr_kind);
   assign rsp_valid_in = accept || req_stall;
   assign thr_plus_one = NW'(pick_thr) + NW'(1);

   always_comb begin
      wait_in          = wait_ff;
      pc_in            = pc_ff;
      halted_in        = halted_ff;
      current_in       = current_ff;
      penalty_left_in  = penalty_left_ff;
      cycle_in         = cycle_ff;
      instr_in         = instr_ff;
      issued_in        = 1'b0;
      issue_thread_in  = '0;
      issue_pc_in      = '0;
      penalty_cycle_in = 1'b0;
      if (plan.act != ACT_DONE) begin
         for (int i = 0; i < MAX_THREADS; i++) begin
            if (wait_ff[i] != '0) begin
               wait_in[i] = wait_ff[i] - WW'(1);
            end
         end
         if (cycle_ff != '1) begin
            cycle_in = cycle_ff + COUNT_WIDTH'(1);
         end
         case (plan.act)
            ACT_PENALTY: begin
               penalty_cycle_in = 1'b1;
               if (plan.new_switch) begin
                  current_in      = pick_thr;
                  penalty_left_in = switch_penalty_ff - PENALTY_WIDTH'(1);
               end else begin
                  penalty_left_in = penalty_left_ff - PENALTY_WIDTH'(1);
               end
            end
            ACT_ISSUE: begin
               issued_in        = 1'b1;
               issue_thread_in  = pick_thr;
               issue_pc_in      = pc_ff[pick_thr];
               pc_in[pick_thr]  = pc_ff[pick_thr] + PC_WIDTH'(1);
               if (instr_ff != '1) begin
                  instr_in = instr_ff + COUNT_WIDTH'(1);
               end
               // The issuing thread's wait is set to exactly the latency, in place of this cycle's countdown.
               case (kind)
                  KIND_LOAD:  wait_in[pick_thr] = WW'(load_latency_ff);
                  KIND_STORE: wait_in[pick_thr] = WW'(store_latency_ff);
                  KIND_HALT:  halted_in[pick_thr] = 1'b1;
                  default: ;
               endcase
               if (fine_mode_ff) begin
                  current_in = (thr_plus_one == use_count) ? '0 : TW'(thr_plus_one);
               end else begin
                  current_in = pick_thr;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_THREADS; i++) begin
            wait_ff[i] <= '0;
            pc_ff[i]   <= '0;
         end
         halted_ff       <= '0;
         current_ff      <= '0;
         penalty_left_ff <= '0;
         cycle_ff        <= '0;
         instr_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            wait_ff         <= wait_in;
            pc_ff           <= pc_in;
            halted_ff       <= halted_in;
            current_ff      <= current_in;
            penalty_left_ff <= penalty_left_in;
            cycle_ff        <= cycle_in;
            instr_ff        <= instr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         issued_ff        <= issued_in;
         issue_thread_ff  <= issue_thread_in;
         issue_pc_ff      <= issue_pc_in;
         penalty_cycle_ff <= penalty_cycle_in;
      end
   end

   // The state only moves on a transfer, so the look-ahead fields taken from
   // it stay matched to the held result.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_issued        = issued_ff;
   assign rsp_issue_thread  = issue_thread_ff;
   assign rsp_issue_pc      = issue_pc_ff;
   assign rsp_penalty_cycle = penalty_cycle_ff;
   assign rsp_next_issues   = plan.act == ACT_ISSUE;
   assign rsp_coming_thread = (plan.act == ACT_ISSUE) ? pick_thr : '0;
   assign rsp_next_pc       = (plan.act == ACT_ISSUE) ? pc_ff[pick_thr] : '0;
   assign rsp_all_halted    = plan.all_halted;
   assign rsp_cycle_total   = cycle_ff;
   assign rsp_instr_total   = instr_ff;

endmodule

[tb/multithread_issue_scheduler_tb.sv]
// Self-checking testbench for the multithread issue scheduler with a built-in cycle predictor.
module multithread_issue_scheduler_tb;
   import mts_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 40;
   localparam int HOLD_CYCLES = 80;
   localparam int LAST_THREAD = MAX_THREADS_DEF - 1;

   typedef struct packed {
      logic        issued;
      logic [2:0]  issue_thread;
      logic [15:0] issue_pc;
      logic        penalty_cycle;
      logic        next_issues;
      logic [2:0]  coming_thread;
      logic [15:0] next_pc;
      logic        all_halted;
      logic [31:0] cycle_total;
      logic [31:0] instr_total;
   } outcome_type;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_op_type;

   typedef struct packed {
      row_op_type    op;
      reg_index_type idx;
      logic [7:0]    value;
      kind_type      kind;
      logic          issued;
      logic [2:0]    thread;
      logic          penalty;
      logic          halted;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [26] = '{
      '{ROW_CFG,  REG_THREAD_COUNT,   8'd0,   KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_PLAIN, 1'b1, 3'd0, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_HALT,  1'b1, 3'd0, 1'b0, 1'b1},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_LOAD,  1'b0, 3'd0, 1'b0, 1'b1},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_STORE, 1'b0, 3'd0, 1'b0, 1'b1},
      '{ROW_CFG,  REG_THREAD_COUNT,   8'd15,  KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_CFG,  REG_LOAD_LATENCY,   8'd255, KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_CFG,  REG_STORE_LATENCY,  8'd255, KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_CFG,  REG_SWITCH_PENALTY, 8'd2,   KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_PLAIN, 1'b0, 3'd0, 1'b1, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_PLAIN, 1'b0, 3'd0, 1'b1, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_LOAD,  1'b1, 3'd1, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_STORE, 1'b0, 3'd0, 1'b1, 1'b0},
      '{ROW_CFG,  REG_FINE_MODE,      8'd1,   KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_STORE, 1'b0, 3'd0, 1'b1, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_STORE, 1'b1, 3'd2, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_LOAD,  1'b1, 3'd3, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_PLAIN, 1'b1, 3'd4, 1'b0, 1'b0},
      '{ROW_CFG,  REG_THREAD_COUNT,   8'd3,   KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_HALT,  1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_CFG,  REG_THREAD_COUNT,   8'd8,   KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_CFG,  REG_LOAD_LATENCY,   8'd0,   KIND_PLAIN, 1'b0, 3'd0, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_LOAD,  1'b1, 3'd5, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_PLAIN, 1'b1, 3'd6, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_PLAIN, 1'b1, 3'd7, 1'b0, 1'b0},
      '{ROW_ITEM, REG_FINE_MODE,      8'd0,   KIND_PLAIN, 1'b1, 3'd4, 1'b0, 1'b0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_instr_kind = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_issued;
   logic [2:0]  rsp_issue_thread;
   logic [15:0] rsp_issue_pc;
   logic        rsp_penalty_cycle;
   logic        rsp_next_issues;
   logic [2:0]  rsp_coming_thread;
   logic [15:0] rsp_next_pc;
   logic        rsp_all_halted;
   logic [31:0] rsp_cycle_total;
   logic [31:0] rsp_instr_total;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   // Predictor copy of the scheduler state and its registers.
   logic        fine_mode_s;
   logic [7:0]  load_lat_s, store_lat_s, penalty_s;
   logic [3:0]  tcount_s;
   logic [8:0]  wait_s [MAX_THREADS_DEF];
   logic        halted_s [MAX_THREADS_DEF];
   logic [15:0] pc_s [MAX_THREADS_DEF];
   int unsigned cur_s;
   logic [7:0]  pen_left_s;
   logic [31:0] cycles_s, instrs_s;

   outcome_type pending_outcomes [$];
   outcome_type seen;
   bit          offering;
   int unsigned send_idle_pct, recv_idle_pct;
   int unsigned mismatches, transfers_sent, results_checked, settings_used;
   int unsigned issues_seen, penalties_seen, quiet_seen, frozen_seen;
   int unsigned hold_left;
   bit          hold_done;
   int unsigned cycle_count;

   multithread_issue_scheduler u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_outcomes.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at result %0d: %s", results_checked, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   function automatic int unsigned live_threads();
      if (tcount_s == 4'd0) return 1;
      if (tcount_s > 4'(MAX_THREADS_DEF)) return MAX_THREADS_DEF;
      return int'(tcount_s);
   endfunction

   function automatic logic every_live_halted();
      int unsigned n, i;
      n = live_threads();
      for (i = 0; i < n; i++)
         if (!halted_s[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void choose_action(output act_type act, output int unsigned thr,
                                         output logic fresh_switch);
      int unsigned n, base, t, i;
      logic found;
      n = live_threads();
      base = cur_s % n;
      found = 1'b0;
      t = 0;
      act = ACT_IDLE;
      thr = 0;
      fresh_switch = 1'b0;
      if (every_live_halted()) begin
         act = ACT_DONE;
         return;
      end
      if (pen_left_s != 8'd0) begin
         act = ACT_PENALTY;
         thr = base;
         return;
      end
      for (i = 0; i < n && !found; i++) begin
         t = (base + i) % n;
         if (wait_s[t] == 9'd0 && !halted_s[t]) found = 1'b1;
      end
      if (!found) return;
      thr = t;
      if (!fine_mode_s && t != base && penalty_s != 8'd0) begin
         act = ACT_PENALTY;
         fresh_switch = 1'b1;
      end else begin
         act = ACT_ISSUE;
      end
   endfunction

   function automatic outcome_type schedule_cycle(input kind_type k);
      outcome_type o;
      act_type act, nact;
      int unsigned thr, nthr, n, i;
      logic fresh, nfresh;
      o = '0;
      n = live_threads();
      choose_action(act, thr, fresh);
      if (act != ACT_DONE) begin
         if (act == ACT_PENALTY) begin
            o.penalty_cycle = 1'b1;
            if (fresh) begin
               cur_s = thr;
               pen_left_s = penalty_s - 8'd1;
            end else begin
               pen_left_s = pen_left_s - 8'd1;
            end
         end else if (act == ACT_ISSUE) begin
            o.issued = 1'b1;
            o.issue_thread = 3'(thr);
            o.issue_pc = pc_s[thr];
            if (instrs_s != 32'hFFFF_FFFF) instrs_s++;
            pc_s[thr] = pc_s[thr] + 16'd1;
            case (k)
               KIND_LOAD: wait_s[thr] = {1'b0, load_lat_s} + 9'd1;
               KIND_STORE: wait_s[thr] = {1'b0, store_lat_s} + 9'd1;
               KIND_HALT: halted_s[thr] = 1'b1;
               default: ;
            endcase
            cur_s = fine_mode_s ? (thr + 1) % n : thr;
         end
         for (i = 0; i < MAX_THREADS_DEF; i++)
            if (wait_s[i] != 9'd0) wait_s[i] = wait_s[i] - 9'd1;
         if (cycles_s != 32'hFFFF_FFFF) cycles_s++;
      end
      choose_action(nact, nthr, nfresh);
      if (nact == ACT_ISSUE) begin
         o.next_issues = 1'b1;
         o.coming_thread = 3'(nthr);
         o.next_pc = pc_s[nthr];
      end
      o.all_halted = every_live_halted();
      o.cycle_total = cycles_s;
      o.instr_total = instrs_s;
      return o;
   endfunction

   task automatic clear_predictor();
      int unsigned i;
      fine_mode_s = 1'b0;
      load_lat_s = 8'd0;
      store_lat_s = 8'd0;
      penalty_s = 8'd0;
      tcount_s = 4'd8;
      for (i = 0; i < MAX_THREADS_DEF; i++) begin
         wait_s[i] = '0;
         halted_s[i] = 1'b0;
         pc_s[i] = '0;
      end
      cur_s = 0;
      pen_left_s = '0;
      cycles_s = '0;
      instrs_s = '0;
   endtask

   task automatic compare_outcome(input outcome_type got);
      outcome_type want;
      if (pending_outcomes.size() == 0) begin
         flag_mismatch("result arrived with nothing expected");
         return;
      end
      want = pending_outcomes.pop_front();
      compare_field("issued", 32'(got.issued), 32'(want.issued));
      compare_field("issue_thread", 32'(got.issue_thread), 32'(want.issue_thread));
      compare_field("issue_pc", 32'(got.issue_pc), 32'(want.issue_pc));
      compare_field("penalty_cycle", 32'(got.penalty_cycle), 32'(want.penalty_cycle));
      compare_field("next_issues", 32'(got.next_issues), 32'(want.next_issues));
      compare_field("coming_thread", 32'(got.coming_thread), 32'(want.coming_thread));
      compare_field("next_pc", 32'(got.next_pc), 32'(want.next_pc));
      compare_field("all_halted", 32'(got.all_halted), 32'(want.all_halted));
      compare_field("cycle_total", got.cycle_total, want.cycle_total);
      compare_field("instr_total", got.instr_total, want.instr_total);
      results_checked++;
      if (want.issued) issues_seen++;
      else if (want.penalty_cycle) penalties_seen++;
      else quiet_seen++;
      if (want.all_halted) frozen_seen++;
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_checked >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_issued, rsp_issue_thread, rsp_issue_pc, rsp_penalty_cycle,
                 rsp_next_issues, rsp_coming_thread, rsp_next_pc, rsp_all_halted,
                 rsp_cycle_total, rsp_instr_total};
         compare_outcome(seen);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic stop_offer();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic offer_item(input kind_type k, output outcome_type want);
      req_valid <= 1'b1;
      req_instr_kind <= k;
      offering = 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      want = schedule_cycle(k);
      transfers_sent++;
   endtask

   task automatic sender_gap();
      if ($urandom_range(0, 99) < send_idle_pct) begin
         stop_offer();
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      stop_offer();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic program_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      case (idx)
         REG_FINE_MODE: begin
            fine_mode_s = value[0];
            readback = {31'd0, value[0]};
         end
         REG_LOAD_LATENCY: begin
            load_lat_s = value[7:0];
            readback = {24'd0, value[7:0]};
         end
         REG_STORE_LATENCY: begin
            store_lat_s = value[7:0];
            readback = {24'd0, value[7:0]};
         end
         REG_SWITCH_PENALTY: begin
            penalty_s = value[7:0];
            readback = {24'd0, value[7:0]};
         end
         default: begin
            tcount_s = value[3:0];
            readback = {28'd0, value[3:0]};
         end
      endcase
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'(32'(idx) << CSR_INDEX_LSB);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== readback)
         flag_mismatch($sformatf("register %s reads 0x%0h, expected 0x%0h",
                                 idx.name(), csr_prdata, readback));
   endtask

   task automatic csr_idle();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                            input logic fine, input logic [7:0] lat_load,
                            input logic [7:0] lat_store, input logic [7:0] pen,
                            input logic [3:0] count, input int unsigned n_items,
                            input int unsigned halt_from);
      outcome_type want;
      kind_type k;
      act_type act;
      int unsigned thr, r, i;
      logic fresh;
      wait_idle();
      program_register(REG_FINE_MODE, 32'(fine));
      program_register(REG_LOAD_LATENCY, 32'(lat_load));
      program_register(REG_STORE_LATENCY, 32'(lat_store));
      program_register(REG_SWITCH_PENALTY, 32'(pen));
      program_register(REG_THREAD_COUNT, 32'(count));
      csr_idle();
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      settings_used++;
      for (i = 0; i < n_items; i++) begin
         choose_action(act, thr, fresh);
         r = $urandom_range(0, 99);
         if (i >= halt_from && r >= 60) k = KIND_HALT;
         else if (r < 45) k = KIND_PLAIN;
         else if (r < 70) k = KIND_LOAD;
         else if (r < 95) k = KIND_STORE;
         else k = (act != ACT_ISSUE || thr == LAST_THREAD) ? KIND_HALT : KIND_PLAIN;
         offer_item(k, want);
         pending_outcomes = {pending_outcomes, want};
         sender_gap();
      end
   endtask

   initial begin
      int unsigned n;
      stim_row_type row;
      outcome_type want;
      clear_predictor();
      send_idle_pct = 7;
      recv_idle_pct = 50;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      settings_used = 1;
      for (n = 0; n < 26; n++) begin
         row = DIRECTED_ROWS[n];
         if (row.op == ROW_CFG) begin
            wait_idle();
            program_register(row.idx, 32'(row.value));
            if (n == 25 || DIRECTED_ROWS[n + 1].op != ROW_CFG) csr_idle();
         end else begin
            offer_item(row.kind, want);
            want.issued = row.issued;
            want.issue_thread = row.thread;
            want.penalty_cycle = row.penalty;
            want.all_halted = row.halted;
            pending_outcomes = {pending_outcomes, want};
            sender_gap();
         end
      end

      run_phase(7, 50, 1'b0, 8'd4, 8'd1, 8'd0, 4'd8, 160, 160);
      run_phase(7, 50, 1'b0, 8'd20, 8'd7, 8'd3, 4'd5, 160, 160);
      run_phase(50, 7, 1'b1, 8'd2, 8'd0, 8'd1, 4'd8, 160, 160);
      run_phase(50, 7, 1'b0, 8'd255, 8'd255, 8'd255, 4'd8, 60, 60);
      run_phase(0, 0, 1'b1, 8'd0, 8'd9, 8'd0, 4'd2, 150, 150);
      run_phase(0, 0, 1'b0, 8'd1, 8'd2, 8'd1, 4'd8, 260, 220);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Covered %0d transfers over %0d register settings: %0d issues, %0d penalty cycles,",
               transfers_sent, settings_used, issues_seen, penalties_seen);
      $display("%0d idle or frozen cycles, %0d results with every thread in use halted.",
               quiet_seen, frozen_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
